/* rtl/core/sdfp_pkg.sv */
// ----------------------------------------------------------------------------
// Sonar distance frame parser package
// Frame layout constants and the divide-by-1000 digit step constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sdfp_pkg;

    // Header bytes that open a frame.
    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h52;

    // Frame positions, counted from the first header byte.
    localparam logic [3:0] HDR_SECOND_POS = 4'd1;
    localparam logic [3:0] DIST_FIRST_POS = 4'd8;
    localparam logic [3:0] DIST_LAST_POS  = 4'd11;
    localparam logic [3:0] CONF_POS       = 4'd12;
    localparam logic [3:0] CHECK_POS      = 4'd13;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int DEPTH_W = 23;
    localparam int REM_W   = 10;
    localparam int POS_W   = 4;

    // Divisor and its reciprocal: floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT
    // holds exactly for every x below 2^18.
    localparam int          DEPTH_DIV   = 1000;
    localparam int          DIVIDEND_W  = REM_W + BYTE_W;
    localparam int          RECIP_W     = 19;
    localparam logic [18:0] RECIP       = 19'd268436;
    localparam int          RECIP_SHIFT = 28;
    localparam int          PROD_W      = DIVIDEND_W + RECIP_W;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [REM_W-1:0]   rem_t;
    typedef logic [POS_W-1:0]   pos_t;

    // Quotient and remainder of the distance seen so far, divided by 1000.
    typedef struct packed {
        depth_t quot;
        rem_t   rem;
    } div_state_t;

endpackage

`default_nettype wire

/* rtl/core/sdfp_if.sv */
// ----------------------------------------------------------------------------
// Sonar distance frame parser channels
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
`default_nettype none

// Received byte channel.
interface sdfp_in_if;
    logic              valid;
    logic              ready;
    sdfp_pkg::byte_t   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Frame result channel.
interface sdfp_out_if;
    logic              valid;
    logic              ready;
    sdfp_pkg::depth_t  depth_scaled;
    sdfp_pkg::byte_t   confidence;
    logic              checksum_ok;

    modport source (output valid, output depth_scaled, output confidence,
                    output checksum_ok, input ready);
    modport sink   (input valid, input depth_scaled, input confidence,
                    input checksum_ok, output ready);
endinterface

`default_nettype wire

/* rtl/core/sdfp_div_step.sv */
// ----------------------------------------------------------------------------
// Divide-by-1000 digit step
// Folds one more distance byte into a running quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfp_div_step (
    input  wire sdfp_pkg::div_state_t cur,
    input  wire sdfp_pkg::byte_t      digit,
    output wire sdfp_pkg::div_state_t nxt
);
    import sdfp_pkg::*;

    logic [DIVIDEND_W-1:0] dividend;
    logic [PROD_W-1:0]     prod;
    logic [BYTE_W-1:0]     q_digit;
    logic [DIVIDEND_W-1:0] q_times_div;
    logic [DIVIDEND_W-1:0] rem_wide;

    // The remainder is below 1000, so remainder * 256 + byte is below 2^18.
    assign dividend = {cur.rem, digit};

    // Quotient digit through the exact reciprocal; it is always below 256.
    assign prod    = PROD_W'(dividend) * PROD_W'(RECIP);
    assign q_digit = prod[RECIP_SHIFT +: BYTE_W];

    // q * 1000 as q * 1024 - q * 16 - q * 8.
    assign q_times_div = (DIVIDEND_W'(q_digit) << 10)
                       - (DIVIDEND_W'(q_digit) << 4)
                       - (DIVIDEND_W'(q_digit) << 3);
    assign rem_wide    = dividend - q_times_div;

    // New quotient is the old one shifted up a byte plus the new digit.
    assign nxt.quot = {cur.quot[DEPTH_W-BYTE_W-1:0], q_digit};
    assign nxt.rem  = rem_wide[REM_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/sonar_distance_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// Sonar distance frame parser
// Finds 0x42 0x52 framed distance messages in a byte stream and reports them.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on in_ch unless stalled and, for
// each complete frame (two header bytes, eleven payload bytes, one check byte),
// gives one item on out_ch: the 32-bit distance divided by 1000, the confidence
// byte and a checksum flag; on a bad checksum the distance and confidence read
// zero. Bytes outside a frame that do not continue the header are dropped. Each
// byte passes an input register, and a result register that drives out_ch is
// loaded as the check byte leaves it; the divide by 1000 is done one distance
// byte at a time as the bytes arrive, by a single digit step. A result waiting
// on out_ch stalls only a following check byte.
`default_nettype none

module sonar_distance_frame_parser_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sdfp_in_if.sink    in_ch,
    sdfp_out_if.source out_ch
);
    import sdfp_pkg::*;

    // Input register.
    logic       in_vld_reg;
    byte_t      in_byte_reg;

    // Frame state.
    logic       in_frame_reg, in_frame_next;
    pos_t       pos_reg, pos_next;
    byte_t      sum_reg, sum_next;
    div_state_t div_reg, div_next;
    byte_t      conf_reg, conf_next;

    // Result register.
    logic       out_vld_reg, out_vld_next;
    depth_t     out_depth_reg;
    byte_t      out_conf_reg;
    logic       out_ok_reg;

    logic       emit;
    logic       proc;
    logic       sum_match;
    div_state_t div_cur;
    div_state_t div_step;

    // Only the check byte needs the result register free.
    assign emit  = in_frame_reg && (pos_reg >= CHECK_POS);
    assign proc  = in_vld_reg && (!emit || !out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || proc;

    assign sum_match = (in_byte_reg == sum_reg);

    // The first distance byte starts the division from zero.
    assign div_cur = (pos_reg == DIST_FIRST_POS) ? '0 : div_reg;

    sdfp_div_step u_div_step (
        .cur   (div_cur),
        .digit (in_byte_reg),
        .nxt   (div_step)
    );

    // Input register load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_vld_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.rx_byte;
        end
    end

    // Header hunt, payload accumulation and check byte handling.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        div_next      = div_reg;
        conf_next     = conf_reg;
        if (proc)
        begin
            if (!in_frame_reg)
            begin
                if (in_byte_reg == HDR_FIRST && pos_reg == '0)
                begin
                    sum_next = HDR_FIRST;
                    pos_next = HDR_SECOND_POS;
                end
                else if (in_byte_reg == HDR_SECOND && pos_reg == HDR_SECOND_POS)
                begin
                    sum_next      = sum_reg + HDR_SECOND;
                    pos_next      = pos_reg + 1'b1;
                    in_frame_next = 1'b1;
                end
            end
            else if (!emit)
            begin
                if (pos_reg >= DIST_FIRST_POS && pos_reg <= DIST_LAST_POS)
                begin
                    div_next = div_step;
                end
                else if (pos_reg == CONF_POS)
                begin
                    conf_next = in_byte_reg;
                end
                sum_next = sum_reg + in_byte_reg;
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
                sum_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        conf_reg <= conf_next;
    end

    // Result register.
    always_comb
    begin
        out_vld_next = out_vld_reg && !out_ch.ready;
        if (proc && emit)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            out_depth_reg <= sum_match ? div_reg.quot : '0;
            out_conf_reg  <= sum_match ? conf_reg : '0;
            out_ok_reg    <= sum_match;
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.depth_scaled = out_depth_reg;
    assign out_ch.confidence   = out_conf_reg;
    assign out_ch.checksum_ok  = out_ok_reg;

endmodule

`default_nettype wire

/* rtl/core/sdfp_checker.sv */
// ----------------------------------------------------------------------------
// Sonar distance frame parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfp_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire sdfp_pkg::depth_t depth_scaled,
    input wire sdfp_pkg::byte_t  confidence,
    input wire logic             checksum_ok
);
    import sdfp_pkg::*;

    localparam depth_t DEPTH_MAX = 23'd4294967;

    // A result stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // A stalled result keeps its fields.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(depth_scaled) && $stable(confidence)
                                    && $stable(checksum_ok))
        else $error("stalled result changed");

    // A failed checksum reports no distance and no confidence.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !checksum_ok |-> depth_scaled == '0 && confidence == '0)
        else $error("failed frame reports nonzero fields");

    // A 32-bit distance over 1000 never exceeds its range.
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> depth_scaled <= DEPTH_MAX)
        else $error("scaled depth out of range");

endmodule

bind sonar_distance_frame_parser_top sdfp_checker u_sdfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .depth_scaled (out_ch.depth_scaled),
    .confidence   (out_ch.confidence),
    .checksum_ok  (out_ch.checksum_ok)
);

`default_nettype wire
